>>> design/apsp_pkg.sv
// Package for the all-pairs shortest path block: item structs, codes and
// the microcode program. No dependencies.
package apsp_pkg;

	localparam int OUT_DIST_W = 48;

	typedef enum logic [1:0] {
		KIND_WRITE   = 2'd0,
		KIND_COMPUTE = 2'd1,
		KIND_READ    = 2'd2,
		KIND_NONE    = 2'd3
	} kind_t;

	// register index, taken from paddr[2]
	localparam logic REG_NODE_COUNT = 1'b0;
	localparam logic [4:0] NODE_COUNT_RESET = 5'd16;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         row;
		logic [3:0]         col;
		logic signed [31:0] edge_weight;
		logic               no_edge;
	} in_item_t;

	typedef struct packed {
		logic [3:0]                    out_row;
		logic [3:0]                    out_col;
		logic signed [OUT_DIST_W-1:0]  distance;
		logic                          unreachable;
		logic                          done_res;
	} out_item_t;

	// port 0 read address source
	typedef enum logic [1:0] {
		RSEL_HOST = 2'd0,
		RSEL_IK   = 2'd1,
		RSEL_IJ   = 2'd2
	} rsel_t;

	typedef enum logic [1:0] {
		WR_NONE  = 2'd0,
		WR_DIAG  = 2'd1,
		WR_RELAX = 2'd2
	} wr_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_DIAG = 2'd1,
		CNT_NEST = 2'd2
	} cnt_t;

	typedef enum logic [1:0] {
		JMP_GOTO  = 2'd0,
		JMP_START = 2'd1,
		JMP_DIAG  = 2'd2,
		JMP_NEST  = 2'd3
	} jmp_t;

	localparam int UPC_W = 3;
	localparam logic [UPC_W-1:0] UPC_IDLE = 3'd0;
	localparam logic [UPC_W-1:0] UPC_DIAG = 3'd1;
	localparam logic [UPC_W-1:0] UPC_RD_A = 3'd2;
	localparam logic [UPC_W-1:0] UPC_RD_B = 3'd3;
	localparam logic [UPC_W-1:0] UPC_UPD  = 3'd4;
	localparam logic [UPC_W-1:0] UPC_DONE = 3'd5;

	typedef struct packed {
		rsel_t            rsel;
		logic             cand_ld;
		wr_t              wr;
		cnt_t             cnt;
		jmp_t             jmp;
		logic [UPC_W-1:0] target;
		logic             emit;
	} uc_word_t;

	// datapath controls handed from the sequencer to the top level
	typedef struct packed {
		rsel_t rsel;
		logic  cand_ld;
		wr_t   wr;
		logic  emit;
	} apsp_ctrl_t;

	function automatic uc_word_t uc_rom(input logic [UPC_W-1:0] upc);
		uc_word_t w;
		w = '{RSEL_HOST, 1'b0, WR_NONE, CNT_HOLD, JMP_GOTO, UPC_IDLE, 1'b0};
		unique case (upc)
			UPC_IDLE: w = '{RSEL_HOST, 1'b0, WR_NONE,  CNT_HOLD, JMP_START, UPC_DIAG, 1'b0};
			UPC_DIAG: w = '{RSEL_HOST, 1'b0, WR_DIAG,  CNT_DIAG, JMP_DIAG,  UPC_RD_A, 1'b0};
			UPC_RD_A: w = '{RSEL_IK,   1'b0, WR_NONE,  CNT_HOLD, JMP_GOTO,  UPC_RD_B, 1'b0};
			UPC_RD_B: w = '{RSEL_IJ,   1'b1, WR_NONE,  CNT_HOLD, JMP_GOTO,  UPC_UPD,  1'b0};
			UPC_UPD:  w = '{RSEL_HOST, 1'b0, WR_RELAX, CNT_NEST, JMP_NEST,  UPC_RD_A, 1'b0};
			UPC_DONE: w = '{RSEL_HOST, 1'b0, WR_NONE,  CNT_HOLD, JMP_GOTO,  UPC_IDLE, 1'b1};
			default:  w = '{RSEL_HOST, 1'b0, WR_NONE,  CNT_HOLD, JMP_GOTO,  UPC_IDLE, 1'b0};
		endcase
		return w;
	endfunction

endpackage

>>> design/apsp_seq.sv
// Microcoded sequencer: step counter, control ROM and the k/i/j counters.
// Depends on apsp_pkg.
module apsp_seq import apsp_pkg::*; #(
	parameter int IDX_W = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [IDX_W-1:0] last_idx,
	output apsp_ctrl_t       ctrl,
	output logic             busy,
	output logic [IDX_W-1:0] idx_i,
	output logic [IDX_W-1:0] idx_j,
	output logic [IDX_W-1:0] idx_k
);

	logic [UPC_W-1:0] upc_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	uc_word_t         w;
	logic             i_last, j_last, k_last;

	assign w      = uc_rom(upc_q);
	assign i_last = (i_q == last_idx);
	assign j_last = (j_q == last_idx);
	assign k_last = (k_q == last_idx);

	assign ctrl  = '{w.rsel, w.cand_ld, w.wr, w.emit};
	assign busy  = (upc_q != UPC_IDLE);
	assign idx_i = i_q;
	assign idx_j = j_q;
	assign idx_k = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			upc_q <= UPC_IDLE;
		end else begin
			unique case (w.jmp)
				JMP_GOTO:  upc_q <= w.target;
				JMP_START: upc_q <= go ? w.target : upc_q;
				JMP_DIAG:  upc_q <= i_last ? w.target : upc_q;
				JMP_NEST:  upc_q <= (i_last && j_last && k_last) ? upc_q + UPC_W'(1) : w.target;
				default:   upc_q <= UPC_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else if (go && !busy) begin
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
		end else begin
			unique case (w.cnt)
				CNT_HOLD: ;
				CNT_DIAG: i_q <= i_last ? '0 : i_q + IDX_W'(1);
				CNT_NEST: begin
					// j innermost, then i, then k
					if (j_last) begin
						j_q <= '0;
						if (i_last) begin
							i_q <= '0;
							k_q <= k_q + IDX_W'(1);
						end else begin
							i_q <= i_q + IDX_W'(1);
						end
					end else begin
						j_q <= j_q + IDX_W'(1);
					end
				end
				default: ;
			endcase
		end
	end

endmodule

>>> design/all_pairs_shortest_paths_top.sv
// Top level: distance matrix memory, relaxation datapath, APB register.
// Depends on apsp_pkg and apsp_seq.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-----------------------------
//  command  | start, busy              | cmd (in_item_t)
//  result   | res_strobe (one cycle)   | res (out_item_t)
//  config   | psel, penable, pwrite    | paddr, pwdata, prdata
//
// A read item's result shows in the cycle after the item. A compute item
// holds busy while the diagonal of the n nodes in use is zeroed, then while
// each relaxation runs its read, read and update steps, set by the
// two-read one-write matrix memory. The done result follows.
// Reset clears control state only; the matrix is undefined until written.
// The receiver cannot stall: results are shown for one cycle only.
module all_pairs_shortest_paths_top import apsp_pkg::*; #(
	parameter int MAX_NODES = 16,
	parameter int DIST_BITS = 48
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  in_item_t    cmd,
	output logic        res_strobe,
	output out_item_t   res,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int ADDR_W = $clog2(MAX_NODES * MAX_NODES);
	localparam int ENT_W  = DIST_BITS + 1;
	localparam int DEPTH  = MAX_NODES * MAX_NODES;

	localparam logic signed [64:0] WMAX = (65'sd1 <<< (DIST_BITS - 1)) - 65'sd1;
	localparam logic signed [64:0] WMIN = -WMAX - 65'sd1;
	localparam logic [DIST_BITS-1:0] DMAX = {1'b0, {(DIST_BITS-1){1'b1}}};
	localparam logic [DIST_BITS-1:0] DMIN = {1'b1, {(DIST_BITS-1){1'b0}}};

	function automatic logic [ADDR_W-1:0] addr_of(input logic [IDX_W-1:0] r,
			input logic [IDX_W-1:0] c);
		return ADDR_W'(r) * ADDR_W'(MAX_NODES) + ADDR_W'(c);
	endfunction

	// configuration
	logic [4:0] node_count_q;
	logic       cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT);
	assign prdata = (paddr[2] == REG_NODE_COUNT) ? {27'd0, node_count_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr) begin
			node_count_q <= pwdata[4:0];
		end
	end

	// last node index in use, count clamped to 1..MAX_NODES
	logic [8:0]       nc9;
	logic [IDX_W-1:0] last_idx;

	assign nc9 = 9'(node_count_q);
	always_comb begin
		priority if (nc9 == 9'd0) begin
			last_idx = '0;
		end else if (nc9 > 9'(MAX_NODES)) begin
			last_idx = IDX_W'(MAX_NODES - 1);
		end else begin
			last_idx = IDX_W'(nc9 - 9'd1);
		end
	end

	// command decode
	logic accept, host_wr, host_rd, go, in_range;
	logic [IDX_W-1:0] h_row, h_col;

	assign accept   = start && !busy;
	assign in_range = (cmd.row < MAX_NODES) && (cmd.col < MAX_NODES);
	assign host_wr  = accept && (cmd.kind == KIND_WRITE) && in_range;
	assign host_rd  = accept && (cmd.kind == KIND_READ);
	assign go       = accept && (cmd.kind == KIND_COMPUTE);
	assign h_row    = IDX_W'(cmd.row);
	assign h_col    = IDX_W'(cmd.col);

	// sequencer
	apsp_ctrl_t       ctrl;
	logic [IDX_W-1:0] idx_i, idx_j, idx_k;

	apsp_seq #(.IDX_W(IDX_W)) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.go       (go),
		.last_idx (last_idx),
		.ctrl     (ctrl),
		.busy     (busy),
		.idx_i    (idx_i),
		.idx_j    (idx_j),
		.idx_k    (idx_k)
	);

	// weight clamped into the distance range
	logic signed [64:0]          w65;
	logic signed [DIST_BITS-1:0] w_clamp;

	assign w65 = 65'($signed(cmd.edge_weight));
	always_comb begin
		priority if (w65 > WMAX) begin
			w_clamp = DMAX;
		end else if (w65 < WMIN) begin
			w_clamp = DMIN;
		end else begin
			w_clamp = DIST_BITS'(w65);
		end
	end

	// matrix memory: one write, two registered reads
	logic [ENT_W-1:0]  mem_q [DEPTH];
	logic [ENT_W-1:0]  rd0_q, rd1_q;
	logic [ADDR_W-1:0] ra0, ra1, wa;
	logic [ENT_W-1:0]  wd;
	logic              we;

	always_comb begin
		unique case (ctrl.rsel)
			RSEL_HOST: ra0 = addr_of(h_row, h_col);
			RSEL_IK:   ra0 = addr_of(idx_i, idx_k);
			RSEL_IJ:   ra0 = addr_of(idx_i, idx_j);
			default:   ra0 = addr_of(h_row, h_col);
		endcase
	end
	assign ra1 = addr_of(idx_k, idx_j);

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wa] <= wd;
		end
		rd0_q <= mem_q[ra0];
		rd1_q <= mem_q[ra1];
	end

	// candidate: saturating sum of D[i][k] and D[k][j]
	logic [DIST_BITS:0]     sum;
	logic [DIST_BITS-1:0]   sum_sat;
	logic [DIST_BITS-1:0]   cand_q;
	logic                   cvalid_q;

	assign sum = {rd0_q[DIST_BITS-1], rd0_q[DIST_BITS-1:0]}
		+ {rd1_q[DIST_BITS-1], rd1_q[DIST_BITS-1:0]};
	always_comb begin
		if (sum[DIST_BITS] != sum[DIST_BITS-1]) begin
			sum_sat = sum[DIST_BITS] ? DMIN : DMAX;
		end else begin
			sum_sat = sum[DIST_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cand_ld) begin
			cand_q   <= sum_sat;
			cvalid_q <= rd0_q[DIST_BITS] && rd1_q[DIST_BITS];
		end
	end

	// rd0_q holds D[i][j] during the update step
	logic better;

	assign better = cvalid_q && (!rd0_q[DIST_BITS]
		|| ($signed(cand_q) < $signed(rd0_q[DIST_BITS-1:0])));

	always_comb begin
		we = 1'b0;
		wa = addr_of(h_row, h_col);
		wd = {!cmd.no_edge, cmd.no_edge ? {DIST_BITS{1'b0}} : w_clamp};
		unique case (ctrl.wr)
			WR_NONE:  we = host_wr;
			WR_DIAG: begin
				we = 1'b1;
				wa = addr_of(idx_i, idx_i);
				wd = {1'b1, {DIST_BITS{1'b0}}};
			end
			WR_RELAX: begin
				we = better;
				wa = addr_of(idx_i, idx_j);
				wd = {1'b1, cand_q};
			end
			default:  we = 1'b0;
		endcase
	end

	// result stage
	logic       rd_pend_q, done_q, in_range_q;
	logic [3:0] row_q, col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
			done_q    <= 1'b0;
		end else begin
			rd_pend_q <= host_rd;
			done_q    <= ctrl.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (host_rd) begin
			row_q      <= cmd.row;
			col_q      <= cmd.col;
			in_range_q <= in_range;
		end
	end

	logic              reach_out;
	logic signed [63:0] dist_ext;

	assign reach_out = rd_pend_q && in_range_q && rd0_q[DIST_BITS];
	assign dist_ext  = 64'($signed(rd0_q[DIST_BITS-1:0]));

	assign res_strobe      = rd_pend_q || done_q;
	assign res.out_row     = rd_pend_q ? row_q : 4'd0;
	assign res.out_col     = rd_pend_q ? col_q : 4'd0;
	assign res.distance    = reach_out ? dist_ext[OUT_DIST_W-1:0] : '0;
	assign res.unreachable = rd_pend_q && !reach_out;
	assign res.done_res    = done_q;

endmodule

>>> design/apsp_checker.sv
// Port-level checker for the all-pairs shortest path top, with its bind.
// Depends on apsp_pkg.
module apsp_checker import apsp_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      start,
	input logic      busy,
	input in_item_t  cmd,
	input logic      res_strobe,
	input out_item_t res
);

	// a read item gives its entry in the next cycle
	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_READ |=>
		res_strobe && !res.done_res && res.out_row == $past(cmd.row)
		&& res.out_col == $past(cmd.col))
		else $error("read item gave no matching result");

	// a write item gives nothing
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_WRITE |=> !res_strobe)
		else $error("write item gave a result");

	// busy only rises on a compute item
	a_busy_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start && cmd.kind == KIND_COMPUTE))
		else $error("busy rose without a compute item");

	// the done result closes a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_strobe && res.done_res |-> $past(busy) && !busy)
		else $error("done result outside the end of a compute");

endmodule

bind all_pairs_shortest_paths_top apsp_checker u_apsp_checker (.*);
